// ----- rtl/core/rthsv_pkg.sv -----
// shared constants for the rgb to hsv converter
// no dependencies; imported by every module of the block
package rthsv_pkg;

  // default channel and hue widths
  localparam int CHANNEL_BITS_DEF = 8;
  localparam int HUE_BITS_DEF     = 16;

  // entries in the queue between classifier and divider pipeline
  localparam int QUEUE_DEPTH_DEF  = 4;

  // extra bits over a channel that hold numerators up to 6 * d
  localparam int NUM_EXTRA_BITS   = 3;

endpackage

// ----- rtl/core/rthsv_front.sv -----
// front part: unpacks a pixel, finds max, min and hue sector, forms dividends
// depends on rthsv_pkg
module rthsv_front
  import rthsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int IN_W         = ((3 * CHANNEL_BITS + 7) / 8) * 8,
  parameter int ENTRY_W      = 2 * (CHANNEL_BITS + NUM_EXTRA_BITS) + 3 * CHANNEL_BITS + 1
) (
  input  logic [IN_W-1:0]    pixel,  // red, green, blue from bit 0 up
  output logic [ENTRY_W-1:0] entry   // num, d6, sat dividend, max, gray from bit 0 up
);

  localparam int CB    = CHANNEL_BITS;
  localparam int NUM_W = CB + NUM_EXTRA_BITS;

  logic [CB-1:0]     red, green, blue;
  logic [CB-1:0]     mx, mn, d;
  logic [NUM_W-1:0]  r_e, g_e, b_e, d_e, d6, num;
  logic [2*CB-1:0]   sat_div;
  logic              gray;

  assign red   = pixel[CB-1:0];
  assign green = pixel[2*CB-1:CB];
  assign blue  = pixel[3*CB-1:2*CB];

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
  end

  assign d    = mx - mn;
  assign gray = (d == '0);

  assign r_e = NUM_W'(red);
  assign g_e = NUM_W'(green);
  assign b_e = NUM_W'(blue);
  assign d_e = NUM_W'(d);
  assign d6  = (d_e << 2) + (d_e << 1);

  // sector numerator, red tested first, then green, then blue
  always_comb begin
    if (mx == red) begin
      if (green >= blue) begin
        num = g_e - b_e;
      end else begin
        num = d6 - (b_e - g_e);
      end
    end else if (mx == green) begin
      num = (d_e << 1) + b_e - r_e;
    end else begin
      num = (d_e << 2) + r_e - g_e;
    end
  end

  // full scale times d as shift and subtract
  assign sat_div = {d, {CB{1'b0}}} - (2*CB)'(d);

  assign entry = {gray, mx, sat_div, d6, num};

endmodule

// ----- rtl/core/rthsv_queue.sv -----
// short queue between the classifier and the divider pipeline
// depends on rthsv_pkg for its default depth
module rthsv_queue
  import rthsv_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end else begin
      return p + 1'b1;
    end
  endfunction

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/rthsv_back.sv -----
// back part: bit-per-stage dividers for hue and saturation, last stage drives the output
// depends on rthsv_pkg
module rthsv_back
  import rthsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int HUE_BITS     = HUE_BITS_DEF,
  parameter int ENTRY_W      = 2 * (CHANNEL_BITS + NUM_EXTRA_BITS) + 3 * CHANNEL_BITS + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    entry_valid,
  output logic                    entry_ready,
  input  logic [ENTRY_W-1:0]      entry,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [HUE_BITS-1:0]     hue,
  output logic [CHANNEL_BITS-1:0] saturation,
  output logic [CHANNEL_BITS-1:0] brightness,
  output logic                    is_gray
);

  localparam int CB    = CHANNEL_BITS;
  localparam int HB    = HUE_BITS;
  localparam int NUM_W = CB + NUM_EXTRA_BITS;
  localparam int LAT   = (HB > CB) ? HB : CB;

  // entry fields
  logic [NUM_W-1:0] e_num, e_d6;
  logic [2*CB-1:0]  e_sat_div;
  logic [CB-1:0]    e_mx;
  logic             e_gray;

  assign {e_gray, e_mx, e_sat_div, e_d6, e_num} = entry;

  // stage registers
  logic             v_r    [LAT];
  logic [NUM_W-1:0] hrem_r [LAT];
  logic [HB-1:0]    hq_r   [LAT];
  logic [NUM_W-1:0] d6_r   [LAT];
  logic [CB-1:0]    srem_r [LAT];
  logic [CB-1:0]    slo_r  [LAT];
  logic [CB-1:0]    sq_r   [LAT];
  logic [CB-1:0]    mx_r   [LAT];
  logic             gray_r [LAT];

  logic en;

  // whole pipeline moves when the output is free or being taken
  assign en          = !v_r[LAT-1] || res_ready;
  assign entry_ready = en;

  for (genvar k = 0; k < LAT; k++) begin : g_stage
    logic             v_in, gray_in;
    logic [NUM_W-1:0] hrem_in, d6_in;
    logic [HB-1:0]    hq_in;
    logic [CB-1:0]    srem_in, slo_in, sq_in, mx_in;
    logic [NUM_W:0]   h_t;
    logic             h_ge;
    logic [CB:0]      s_t;
    logic             s_ge;
    logic [NUM_W-1:0] hrem_nxt;
    logic [HB-1:0]    hq_nxt;
    logic [CB-1:0]    srem_nxt, slo_nxt, sq_nxt;

    if (k == 0) begin : g_first
      assign v_in    = entry_valid;
      assign hrem_in = e_num;
      assign hq_in   = '0;
      assign d6_in   = e_d6;
      assign srem_in = e_sat_div[2*CB-1:CB];
      assign slo_in  = e_sat_div[CB-1:0];
      assign sq_in   = '0;
      assign mx_in   = e_mx;
      assign gray_in = e_gray;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign hrem_in = hrem_r[k-1];
      assign hq_in   = hq_r[k-1];
      assign d6_in   = d6_r[k-1];
      assign srem_in = srem_r[k-1];
      assign slo_in  = slo_r[k-1];
      assign sq_in   = sq_r[k-1];
      assign mx_in   = mx_r[k-1];
      assign gray_in = gray_r[k-1];
    end

    // one restoring step of each divider
    assign h_t  = {hrem_in, 1'b0};
    assign h_ge = (h_t >= {1'b0, d6_in});
    assign s_t  = {srem_in, slo_in[CB-1]};
    assign s_ge = (s_t >= {1'b0, mx_in});

    always_comb begin
      hrem_nxt = hrem_in;
      hq_nxt   = hq_in;
      srem_nxt = srem_in;
      slo_nxt  = slo_in;
      sq_nxt   = sq_in;
      if (k < HB) begin
        hrem_nxt = h_ge ? NUM_W'(h_t - {1'b0, d6_in}) : NUM_W'(h_t);
        hq_nxt   = {hq_in[HB-2:0], h_ge};
      end
      if (k < CB) begin
        srem_nxt = s_ge ? CB'(s_t - {1'b0, mx_in}) : CB'(s_t);
        slo_nxt  = slo_in << 1;
        sq_nxt   = {sq_in[CB-2:0], s_ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hrem_r[k] <= hrem_nxt;
        hq_r[k]   <= hq_nxt;
        d6_r[k]   <= d6_in;
        srem_r[k] <= srem_nxt;
        slo_r[k]  <= slo_nxt;
        sq_r[k]   <= sq_nxt;
        mx_r[k]   <= mx_in;
        gray_r[k] <= gray_in;
      end
    end
  end

  // gray pixels carry a zero hue divisor, so both quotients are forced to zero
  assign res_valid  = v_r[LAT-1];
  assign hue        = gray_r[LAT-1] ? '0 : hq_r[LAT-1];
  assign saturation = gray_r[LAT-1] ? '0 : sq_r[LAT-1];
  assign brightness = mx_r[LAT-1];
  assign is_gray    = gray_r[LAT-1];

endmodule

// ----- rtl/core/rgb_to_hsv_converter.sv -----
// rgb to hsv converter top level: classifier, queue and divider pipeline
// depends on rthsv_pkg, rthsv_front, rthsv_queue and rthsv_back
//
// usage
//   in_*  : one pixel per beat, red, green and blue packed in in_tdata
//   out_* : one hsv result per beat, hue, saturation and value in out_tdata,
//           the gray flag in out_tuser
//   path: a beat accepted is written into the queue, then takes one divider
//           step per stage of the divider pipeline
//   throughput: one pixel per clock while the output is not stalled; every divider stage
//           retires at most one quotient bit of each of the hue and the saturation division
//   stall: when a result waits with out_tready low the divider pipeline holds;
//           the queue keeps taking beats until its QUEUE_DEPTH entries are full,
//           then in_tready drops
//   reset: synchronous, active low; empties the queue and all stage
//           valids, so out_tvalid is low and in_tready high afterwards
//   saturation = floor(full * (max - min) / max), hue in units of
//   2^-HUE_BITS of a turn; gray pixels give hue and saturation zero
module rgb_to_hsv_converter
  import rthsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int HUE_BITS     = HUE_BITS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  // red, green, blue from bit 0 up, zero padded to whole bytes
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]               in_tdata,

  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  // hue, saturation, brightness from bit 0 up, zero padded to whole bytes
  output logic [((HUE_BITS+2*CHANNEL_BITS+7)/8)*8-1:0]      out_tdata,
  // is_gray
  output logic                                              out_tuser
);

  localparam int CB      = CHANNEL_BITS;
  localparam int HB      = HUE_BITS;
  localparam int IN_W    = ((3 * CB + 7) / 8) * 8;
  localparam int OUT_W   = ((HB + 2 * CB + 7) / 8) * 8;
  localparam int RES_W   = HB + 2 * CB;
  localparam int ENTRY_W = 2 * (CB + NUM_EXTRA_BITS) + 3 * CB + 1;

  // classified pixel on its way into the queue
  logic [ENTRY_W-1:0] push_entry;

  // queue head towards the divider pipeline
  logic               head_valid;
  logic               head_ready;
  logic [ENTRY_W-1:0] head_entry;

  logic [HB-1:0]      hue;
  logic [CB-1:0]      saturation;
  logic [CB-1:0]      brightness;

  rthsv_front #(
    .CHANNEL_BITS (CB),
    .IN_W         (IN_W),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .pixel (in_tdata),
    .entry (push_entry)
  );

  // lets the front keep taking pixels while the output side stalls
  rthsv_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_data  (push_entry),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head_entry)
  );

  rthsv_back #(
    .CHANNEL_BITS (CB),
    .HUE_BITS     (HB),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_valid (head_valid),
    .entry_ready (head_ready),
    .entry       (head_entry),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .hue         (hue),
    .saturation  (saturation),
    .brightness  (brightness),
    .is_gray     (out_tuser)
  );

  // pack the result beat, padding bits held at zero
  assign out_tdata = OUT_W'({brightness, saturation, hue});

  // keeps the packed width tied to the field widths
  localparam int PAD_W = OUT_W - RES_W;
  if (PAD_W < 0) begin : g_bad_width
    $error("output packing narrower than result fields");
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for the rgb to hsv converter: random and directed pixel beats,
// an in-bench integer hsv predictor and an in-order scoreboard on the result stream
// depends on rthsv_pkg and rgb_to_hsv_converter
module tb;
  import rthsv_pkg::*;

  localparam int CH          = CHANNEL_BITS_DEF;
  localparam int HB          = HUE_BITS_DEF;
  localparam int IN_W        = ((3*CH+7)/8)*8;
  localparam int OUT_W       = ((HB+2*CH+7)/8)*8;
  localparam int CH_FULL     = (1 << CH) - 1;
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off for the fill test
  localparam int DRAIN_WAIT  = 60;
  localparam int CYCLE_LIMIT = 200000;  // far above the slowest correct run

  typedef struct packed {
    logic [CH-1:0] blue;
    logic [CH-1:0] green;
    logic [CH-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic          gray;
    logic [CH-1:0] bright;
    logic [CH-1:0] sat;
    logic [HB-1:0] hue;
  } hsv_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // block ports, inputs known from time zero
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // red, green, blue from bit 0 up
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;          // hue, saturation, brightness from bit 0 up
  logic             out_tuser;          // is_gray

  rgb_to_hsv_converter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // pixels waiting to be sent and hsv results still owed by the block
  pixel_t pixel_q[$];
  hsv_t   hsv_owed_q[$];

  // idling knobs, changed by the sequencer on falling edges only
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req_cnt   = 0;

  int n_errors   = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_gray_in  = 0;
  int n_black_in = 0;
  int n_cycles   = 0;

  // integer hexcone conversion, one pixel to one hsv result
  function automatic hsv_t rgb_to_hsv(pixel_t px);
    longint unsigned r, g, b, mx, mn, d, num;
    hsv_t res;
    r  = px.red;
    g  = px.green;
    b  = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d  = mx - mn;
    res.gray   = (d == 0);
    res.bright = mx[CH-1:0];
    if (d == 0) begin
      res.hue = '0;
    end else begin
      // red wins ties, then green; below-zero red sector wraps by a full turn
      if (mx == r) begin
        num = (g >= b) ? (g - b) : (6 * d - (b - g));
      end else if (mx == g) begin
        num = 2 * d + b - r;
      end else begin
        num = 4 * d + r - g;
      end
      res.hue = HB'((num << HB) / (6 * d));
    end
    // black pixel has no defined saturation, held at zero
    res.sat = (mx == 0) ? '0 : CH'((CH_FULL * d) / mx);
    return res;
  endfunction

  function automatic pixel_t make_pixel(int r, int g, int b);
    pixel_t px;
    px.red   = r[CH-1:0];
    px.green = g[CH-1:0];
    px.blue  = b[CH-1:0];
    return px;
  endfunction

  // random pixel, weighted towards ties, grays and the ends of the range
  function automatic pixel_t random_pixel();
    int r, g, b, v;
    r = $urandom_range(CH_FULL);
    g = $urandom_range(CH_FULL);
    b = $urandom_range(CH_FULL);
    v = $urandom_range(CH_FULL);
    case ($urandom_range(9))
      0:       return make_pixel(v, v, v);
      1:       return make_pixel(v, v, b);
      2:       return make_pixel(v, g, v);
      3:       return make_pixel(r, v, v);
      4:       return make_pixel($urandom_range(3), $urandom_range(3), $urandom_range(3));
      5:       return make_pixel(CH_FULL - $urandom_range(2), g, $urandom_range(2));
      6: begin
        // one channel one above or below another, tiny d against large max
        return make_pixel(v, (v + 1) & CH_FULL, v);
      end
      default: return make_pixel(r, g, b);
    endcase
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("mismatch at cycle %0d: %s expected %0d got %0d", n_cycles, what, exp_v, got_v);
    n_errors++;
  endtask

  // driver: when the current beat is gone or none is up, offers the next pixel or idles at random
  always @(posedge clk) begin
    pixel_t px;
    if (in_tvalid && in_tready) begin
      px = pixel_t'(in_tdata[3*CH-1:0]);
      hsv_owed_q.push_back(rgb_to_hsv(px));
      n_sent++;
      if (px.red == px.green && px.green == px.blue) n_gray_in++;
      if (px == '0) n_black_in++;
    end
    if (!in_tvalid || in_tready) begin
      if (rst_n && pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        px = pixel_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= IN_W'(px);
      end else begin
        in_tvalid <= 1'b0;
        in_tdata  <= IN_W'($urandom);
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: every result beat against the oldest owed result, field by field
  always @(posedge clk) begin
    hsv_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hue    = out_tdata[HB-1:0];
      got.sat    = out_tdata[HB+CH-1:HB];
      got.bright = out_tdata[HB+2*CH-1:HB+CH];
      got.gray   = out_tuser;
      if (hsv_owed_q.size() == 0) begin
        report_mismatch("result with nothing owed, hue", -1, got.hue);
      end else begin
        want = hsv_owed_q.pop_front();
        n_checked++;
        if (got.hue    !== want.hue)    report_mismatch("hue",        want.hue,    got.hue);
        if (got.sat    !== want.sat)    report_mismatch("saturation", want.sat,    got.sat);
        if (got.bright !== want.bright) report_mismatch("brightness", want.bright, got.bright);
        if (got.gray   !== want.gray)   report_mismatch("is_gray",    want.gray,   got.gray);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", n_cycles, hsv_owed_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // wait until every queued pixel has gone in and every result has come out
  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_tvalid) @(negedge clk);
    while (hsv_owed_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int send_pct, int stall_pct, int n_items);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) pixel_q.push_back(random_pixel());
    wait_drained();
  endtask

  // sequencer
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every sector, the tie orders, gray and black
    pixel_q.push_back(make_pixel(0, 0, 0));
    pixel_q.push_back(make_pixel(CH_FULL, CH_FULL, CH_FULL));
    pixel_q.push_back(make_pixel(128, 128, 128));
    pixel_q.push_back(make_pixel(1, 1, 1));
    pixel_q.push_back(make_pixel(CH_FULL, 0, 0));
    pixel_q.push_back(make_pixel(0, CH_FULL, 0));
    pixel_q.push_back(make_pixel(0, 0, CH_FULL));
    pixel_q.push_back(make_pixel(CH_FULL, CH_FULL, 0));
    pixel_q.push_back(make_pixel(CH_FULL, 0, CH_FULL));
    pixel_q.push_back(make_pixel(0, CH_FULL, CH_FULL));
    pixel_q.push_back(make_pixel(CH_FULL, 0, 1));
    pixel_q.push_back(make_pixel(CH_FULL, 1, 0));
    pixel_q.push_back(make_pixel(1, 0, 0));
    pixel_q.push_back(make_pixel(0, 1, 0));
    pixel_q.push_back(make_pixel(0, 0, 1));
    pixel_q.push_back(make_pixel(1, 2, 3));
    pixel_q.push_back(make_pixel(3, 2, 1));
    pixel_q.push_back(make_pixel(CH_FULL - 1, CH_FULL, 0));
    pixel_q.push_back(make_pixel(100, 0, CH_FULL));
    pixel_q.push_back(make_pixel(CH_FULL - 1, CH_FULL, CH_FULL));
    pixel_q.push_back(make_pixel(CH_FULL, CH_FULL - 1, CH_FULL));
    pixel_q.push_back(make_pixel(170, 85, 0));
    wait_drained();

    // random phases, each with its own idling mix
    run_phase(0,  0,  290);
    run_phase(59, 0,  290);
    run_phase(0,  59, 290);
    run_phase(13, 13, 290);

    // fill test: receiver holds off while the sender keeps offering beats
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_cnt++;
    repeat (60) pixel_q.push_back(random_pixel());
    wait_drained();

    repeat (DRAIN_WAIT) @(negedge clk);

    $display("pixels sent %0d, results checked %0d, gray %0d, black %0d",
             n_sent, n_checked, n_gray_in, n_black_in);
    $display("covered idle-free, sender-idle, receiver-stall and mixed phases plus a full stall");
    if (n_errors == 0 && hsv_owed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
